// File: rtl/ring_queue_with_positional_edit_core_macros.svh
// Assertion macros for the ring queue core.
// Used by rtl/ring_queue_with_positional_edit_core.sv; expects clk and rst_n in scope.
`ifndef RING_QUEUE_WITH_POSITIONAL_EDIT_CORE_MACROS_SVH
`define RING_QUEUE_WITH_POSITIONAL_EDIT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define RQPE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define RQPE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RQPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define RQPE_ASSERT_ALWAYS(lbl, cond, msg)
`define RQPE_ASSERT_IMPL(lbl, ante, cons, msg)
`define RQPE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/rqpe_pkg.sv
// Shared types and constants for the ring queue with positional edit.
// No dependencies; imported by every module of the block.
package rqpe_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_INSERT = 2'd3
    } rqpe_req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } rqpe_status_t;

    // slot store write request
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic [DATA_WIDTH-1:0] data;
    } rqpe_wr_t;

    // slot store read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rqpe_rd_t;

endpackage

// File: rtl/rqpe_slot_store.sv
// Slot store of the ring queue: one write port, one read port, registered read data.
// Depends on rqpe_pkg for widths and request structs.
module rqpe_slot_store
    import rqpe_pkg::*;
(
    input  logic                  clk,
    input  rqpe_wr_t              wr,
    input  rqpe_rd_t              rd,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

// File: rtl/ring_queue_with_positional_edit_core.sv
// Top level of the ring queue with positional edit: sequencer, queue pointers, result register.
// Depends on rqpe_pkg, rqpe_slot_store and the assertion macro header.
//
// Ring queue of up to 16 slots of 32 bits; cfg_wr_en/cfg_wr_data set the number of
// slots in use (0 acts as 1, above 16 acts as 16) and empty the queue. Each item is a
// push, pop, delete at a position or insert after a position, and gives one result.
// One item is worked on at a time and in_ready is low until its result is loaded into
// the output register (which may still be waiting while the next item is accepted).
// A rejected item goes straight to the result state; a push writes its slot and a pop
// reads the front slot before the result; a delete or an insert first sets up the walk,
// then moves the elements after the position one by one, and an insert then writes its
// new value into the gap. A result waiting in the output register holds the block in
// the result state. Element moves are paced by the slot store, whose single read and
// single write port move one element per cycle, with all slot addresses coming from one
// shared modulo-capacity adder.
`include "ring_queue_with_positional_edit_core_macros.svh"

module ring_queue_with_positional_edit_core
    import rqpe_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [CNT_W-1:0]             cfg_wr_data,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   req_type,
    input  logic [IDX_W-1:0]             position,
    input  logic signed [DATA_WIDTH-1:0] data_in,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] data_out,
    output logic [1:0]                   status,
    output logic [CNT_W-1:0]             occupancy,
    output logic                         is_empty,
    output logic                         is_full
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SHIFT,
        S_WRITE,
        S_POP,
        S_RESP
    } state_t;

    state_t                state_reg,      state_next;
    rqpe_req_t             req_reg,        req_next;
    rqpe_status_t          stat_reg,       stat_next;
    logic [IDX_W-1:0]      pos_reg,        pos_next;
    logic [DATA_WIDTH-1:0] din_reg,        din_next;
    logic [CNT_W-1:0]      idx_reg,        idx_next;
    logic [IDX_W-1:0]      prev_addr_reg,  prev_addr_next;
    logic [IDX_W-1:0]      wr_addr_reg,    wr_addr_next;
    logic                  pend_reg,       pend_next;
    logic [IDX_W-1:0]      head_reg,       head_next;
    logic [CNT_W-1:0]      count_reg,      count_next;
    logic [CNT_W-1:0]      cap_reg,        cap_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [DATA_WIDTH-1:0] data_out_reg,   data_out_next;
    rqpe_status_t          status_out_reg, status_out_next;
    logic [CNT_W-1:0]      occ_reg,        occ_next;
    logic                  empty_reg,      empty_next;
    logic                  full_reg,       full_next;

    logic [CNT_W-1:0]      cap_eff;
    logic [CNT_W:0]        slot_sum;
    logic [IDX_W-1:0]      slot_addr;
    logic [CNT_W-1:0]      head_plus;
    logic [IDX_W-1:0]      head_inc;
    logic                  more_rd;
    logic                  accept;
    rqpe_req_t             in_req;
    rqpe_wr_t              wr;
    rqpe_rd_t              rd;
    logic [DATA_WIDTH-1:0] rd_data;

    // effective capacity: clamp register into 1..DEPTH
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    // shared address unit: physical slot of logical index idx_reg
    assign slot_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, head_reg} + {1'b0, idx_reg};
    assign slot_addr = (slot_sum >= {1'b0, cap_eff})
                     ? IDX_W'(slot_sum - {1'b0, cap_eff})
                     : slot_sum[IDX_W-1:0];

    // head advance after a pop
    assign head_plus = {{(CNT_W - IDX_W){1'b0}}, head_reg} + CNT_W'(1);
    assign head_inc  = (head_plus == cap_eff) ? '0 : head_plus[IDX_W-1:0];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_req   = rqpe_req_t'(req_type);

    // more elements to move: delete walks up to the rear, insert walks down to pos+1
    assign more_rd = (req_reg == REQ_DELETE) ? (idx_reg < count_reg)
                                             : (idx_reg > {1'b0, pos_reg});

    // slot store ports
    always_comb
    begin
        rd.en   = ((state_reg == S_SHIFT) && more_rd) || (state_reg == S_POP);
        rd.addr = slot_addr;
        wr.en   = ((state_reg == S_SHIFT) && pend_reg) || (state_reg == S_WRITE);
        wr.addr = (state_reg == S_SHIFT) ? wr_addr_reg : slot_addr;
        wr.data = (state_reg == S_SHIFT) ? rd_data : din_reg;
    end

    rqpe_slot_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        stat_next       = stat_reg;
        pos_next        = pos_reg;
        din_next        = din_reg;
        idx_next        = idx_reg;
        prev_addr_next  = prev_addr_reg;
        wr_addr_next    = wr_addr_reg;
        pend_next       = pend_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        out_valid_next  = out_valid_reg;
        data_out_next   = data_out_reg;
        status_out_next = status_out_reg;
        occ_next        = occ_reg;
        empty_next      = empty_reg;
        full_next       = full_reg;

        // result register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = in_req;
                    pos_next  = position;
                    din_next  = data_in;
                    pend_next = 1'b0;
                    stat_next = STAT_OK;
                    unique case (in_req)
                        REQ_PUSH:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_WRITE;
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_POP;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if ({1'b0, position} >= count_reg)
                            begin
                                stat_next  = STAT_RANGE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = {1'b0, position};
                                state_next = S_SETUP;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (count_reg >= cap_eff)
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_RESP;
                            end
                            else if ({1'b0, position} >= count_reg)
                            begin
                                stat_next  = STAT_RANGE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_SETUP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // first write target, then step to the first source
            S_SETUP:
            begin
                prev_addr_next = slot_addr;
                idx_next       = (req_reg == REQ_DELETE) ? idx_reg + CNT_W'(1)
                                                         : idx_reg - CNT_W'(1);
                state_next     = S_SHIFT;
            end

            // one element per cycle: read source, write previous source slot
            S_SHIFT:
            begin
                if (more_rd)
                begin
                    pend_next      = 1'b1;
                    wr_addr_next   = prev_addr_reg;
                    prev_addr_next = slot_addr;
                    idx_next       = (req_reg == REQ_DELETE) ? idx_reg + CNT_W'(1)
                                                             : idx_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (req_reg == REQ_DELETE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = S_RESP;
                        end
                        else
                        begin
                            idx_next   = {1'b0, pos_reg} + CNT_W'(1);
                            state_next = S_WRITE;
                        end
                    end
                end
            end

            // new value into its slot (push rear or insert gap)
            S_WRITE:
            begin
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            // read front slot, advance head
            S_POP:
            begin
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESP;
            end

            // load result once the output register is free
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = stat_reg;
                    data_out_next   = ((req_reg == REQ_POP) && (stat_reg == STAT_OK))
                                    ? rd_data : '0;
                    occ_next        = count_reg;
                    empty_next      = (count_reg == '0);
                    full_next       = (count_reg == cap_eff);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // capacity write empties the queue
        if (cfg_wr_en)
        begin
            cap_next   = cfg_wr_data;
            head_next  = '0;
            count_next = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= REQ_PUSH;
            stat_reg       <= STAT_OK;
            pos_reg        <= '0;
            din_reg        <= '0;
            idx_reg        <= '0;
            prev_addr_reg  <= '0;
            wr_addr_reg    <= '0;
            pend_reg       <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            cap_reg        <= CNT_W'(DEPTH);
            out_valid_reg  <= 1'b0;
            data_out_reg   <= '0;
            status_out_reg <= STAT_OK;
            occ_reg        <= '0;
            empty_reg      <= 1'b1;
            full_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            stat_reg       <= stat_next;
            pos_reg        <= pos_next;
            din_reg        <= din_next;
            idx_reg        <= idx_next;
            prev_addr_reg  <= prev_addr_next;
            wr_addr_reg    <= wr_addr_next;
            pend_reg       <= pend_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            out_valid_reg  <= out_valid_next;
            data_out_reg   <= data_out_next;
            status_out_reg <= status_out_next;
            occ_reg        <= occ_next;
            empty_reg      <= empty_next;
            full_reg       <= full_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = signed'(data_out_reg);
    assign status    = status_out_reg;
    assign occupancy = occ_reg;
    assign is_empty  = empty_reg;
    assign is_full   = full_reg;

    // checks
    `RQPE_ASSERT_ALWAYS(a_count_le_cap, count_reg <= cap_eff, "element count above capacity")
    `RQPE_ASSERT_ALWAYS(a_head_lt_cap, head_reg < cap_eff[IDX_W-1:0] || cap_eff == CNT_W'(DEPTH), "head outside ring")
    `RQPE_ASSERT_IMPL(a_wr_in_ring, wr.en, {1'b0, wr.addr} < cap_eff, "slot write outside ring")
    `RQPE_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready right after accepting an item")
    `RQPE_ASSERT_IMPL(a_data_zero_unless_pop, out_valid_reg && (status_out_reg != STAT_OK), data_out_reg == '0, "data on a failed request")

endmodule

// File: dv/ring_queue_with_positional_edit_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ring_queue_with_positional_edit_core.
// Depends on rqpe_pkg and the core RTL; a built-in queue model predicts every result.

module ring_queue_with_positional_edit_core_tb;
    import rqpe_pkg::*;

    localparam int TIMEOUT_NS = 5_000_000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [DATA_WIDTH-1:0] data;
        rqpe_status_t          st;
        logic [CNT_W-1:0]      occ;
        logic                  empty;
        logic                  full;
    } queue_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [CNT_W-1:0]             cfg_wr_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   req_type;
    logic [IDX_W-1:0]             position;
    logic signed [DATA_WIDTH-1:0] data_in;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [DATA_WIDTH-1:0] data_out;
    logic [1:0]                   status;
    logic [CNT_W-1:0]             occupancy;
    logic                         is_empty;
    logic                         is_full;

    // queue model state
    logic [DATA_WIDTH-1:0] model_slots [DEPTH];
    logic [CNT_W-1:0]      model_cap_reg;
    int unsigned           model_head;
    int unsigned           model_tail;
    int unsigned           model_count;

    queue_result_t awaited_results [$];
    int            error_count;
    bit            offering;
    int            burst_left;
    bit            hold_req;

    ring_queue_with_positional_edit_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .position    (position),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .status      (status),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Queue model
    // ---------------------------------------------------------------

    // register value clamped to 1..DEPTH
    function automatic int unsigned slots_in_use();
        int unsigned c;
        c = 32'(model_cap_reg);
        if (c == 0)
            c = 1;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned slot_at(int unsigned i);
        return (model_head + i) % slots_in_use();
    endfunction

    function automatic void clear_queue_model();
        model_head  = 0;
        model_tail  = slots_in_use() - 1;
        model_count = 0;
    endfunction

    // apply one request to the model and return the result it gives
    function automatic queue_result_t predict_queue_result(rqpe_req_t req,
                                                           logic [IDX_W-1:0] pos,
                                                           logic [DATA_WIDTH-1:0] din);
        queue_result_t r;
        int unsigned   cap;
        int unsigned   p;
        int unsigned   i;
        cap    = slots_in_use();
        p      = 32'(pos);
        r.data = '0;
        r.st   = STAT_OK;
        case (req)
            REQ_PUSH:
            begin
                if (model_count >= cap)
                    r.st = STAT_FULL;
                else
                begin
                    model_tail = (model_tail + 1) % cap;
                    model_slots[model_tail] = din;
                    model_count++;
                end
            end
            REQ_POP:
            begin
                if (model_count == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    r.data = model_slots[model_head];
                    model_head = (model_head + 1) % cap;
                    model_count--;
                end
            end
            REQ_DELETE:
            begin
                if (p >= model_count)
                    r.st = STAT_RANGE;
                else
                begin
                    // later elements slide toward the front
                    for (i = p; i + 1 < model_count; i++)
                        model_slots[slot_at(i)] = model_slots[slot_at(i + 1)];
                    model_tail = (model_tail + cap - 1) % cap;
                    model_count--;
                end
            end
            default:
            begin
                // full is checked before range
                if (model_count >= cap)
                    r.st = STAT_FULL;
                else if (p >= model_count)
                    r.st = STAT_RANGE;
                else
                begin
                    for (i = model_count; i > p + 1; i--)
                        model_slots[slot_at(i)] = model_slots[slot_at(i - 1)];
                    model_slots[slot_at(p + 1)] = din;
                    model_tail = (model_tail + 1) % cap;
                    model_count++;
                end
            end
        endcase
        r.occ   = model_count[CNT_W-1:0];
        r.empty = (model_count == 0);
        r.full  = (model_count == cap);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output stalls
    // ---------------------------------------------------------------

    function automatic void compare_field(string name, logic [31:0] exp_val,
                                          logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                     act_val);
        end
    endfunction

    function automatic void check_result();
        queue_result_t e;
        if (awaited_results.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual data %h status %0d occ %0d",
                     $time, data_out, status, occupancy);
        end
        else
        begin
            e = awaited_results.pop_front();
            compare_field("data_out", e.data, data_out);
            compare_field("status", 32'(e.st), 32'(status));
            compare_field("occupancy", 32'(e.occ), 32'(occupancy));
            compare_field("is_empty", 32'(e.empty), 32'(is_empty));
            compare_field("is_full", 32'(e.full), 32'(is_full));
        end
    endfunction

    // receiver: alternating ready/stall runs, plus a long hold on request
    initial
    begin
        int  hold_left;
        int  run_left;
        bit  ready_phase;
        hold_left   = 0;
        run_left    = 0;
        ready_phase = 1'b0;
        out_ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_result();
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    ready_phase = !ready_phase;
                    if (ready_phase)
                        run_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 10);
                    else
                        run_left = $urandom_range(1, 8);
                end
                run_left--;
                out_ready <= ready_phase;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // offer one item, wait for acceptance, then maybe open a gap
    task automatic send_item(input rqpe_req_t req, input logic [IDX_W-1:0] pos,
                             input logic [DATA_WIDTH-1:0] din);
        if (!offering)
            in_valid <= 1'b1;
        offering = 1'b1;
        req_type <= req;
        position <= pos;
        data_in  <= din;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_results.push_back(predict_queue_result(req, pos, din));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
    endtask

    // stop offering and wait for every pending result
    task automatic wait_all_results();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        wait_all_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_cap_reg = value;
        clear_queue_model();
    endtask

    function automatic logic [DATA_WIDTH-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // random items; grow_pct sets how often the request adds an element
    task automatic run_random_items(input int n, input int grow_pct);
        rqpe_req_t        req;
        logic [IDX_W-1:0] pos;
        int               k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < grow_pct)
                req = $urandom_range(0, 1) ? REQ_PUSH : REQ_INSERT;
            else
                req = $urandom_range(0, 1) ? REQ_POP : REQ_DELETE;
            // mostly a held position, sometimes just past the end or anywhere
            if (model_count != 0 && $urandom_range(0, 3) != 0)
                pos = IDX_W'($urandom_range(0, model_count - 1));
            else if (model_count < DEPTH && $urandom_range(0, 1) == 0)
                pos = model_count[IDX_W-1:0];
            else
                pos = IDX_W'($urandom_range(0, DEPTH - 1));
            send_item(req, pos, random_word());
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // edge cases at reset capacity, then tiny rings
    task automatic test_directed_edges();
        send_item(REQ_POP, 0, 32'h0);
        send_item(REQ_DELETE, 0, 32'h0);
        send_item(REQ_INSERT, 0, 32'h1234_5678);
        send_item(REQ_PUSH, 0, 32'h8000_0000);
        send_item(REQ_PUSH, 0, 32'h7FFF_FFFF);
        send_item(REQ_PUSH, 0, 32'h0000_0000);
        send_item(REQ_PUSH, 0, 32'hFFFF_FFFF);
        send_item(REQ_INSERT, 0, 32'h5555_5555);
        send_item(REQ_INSERT, 4, 32'hAAAA_AAAA);
        send_item(REQ_DELETE, 6, 32'h0);
        send_item(REQ_DELETE, 15, 32'h0);
        send_item(REQ_DELETE, 5, 32'h0);
        send_item(REQ_DELETE, 0, 32'h0);
        send_item(REQ_POP, 0, 32'h0);
        // two slots: full on push and on insert, even with a bad position
        write_capacity(5'd2);
        send_item(REQ_PUSH, 0, 32'hDEAD_BEEF);
        send_item(REQ_PUSH, 0, 32'h0BAD_F00D);
        send_item(REQ_PUSH, 0, 32'h1111_1111);
        send_item(REQ_INSERT, 15, 32'h2222_2222);
        send_item(REQ_POP, 0, 32'h0);
        send_item(REQ_POP, 0, 32'h0);
        send_item(REQ_POP, 0, 32'h0);
        // zero acts as a one-slot ring
        write_capacity(5'd0);
        send_item(REQ_PUSH, 0, 32'hCAFE_0001);
        send_item(REQ_INSERT, 0, 32'hCAFE_0002);
        send_item(REQ_PUSH, 0, 32'hCAFE_0003);
        send_item(REQ_DELETE, 0, 32'h0);
    endtask

    // random traffic across capacity settings, filling and draining each
    task automatic test_capacity_settings();
        logic [CNT_W-1:0] caps [6];
        int               k;
        caps = '{5'd16, 5'd1, 5'd31, 5'd17, 5'd0, 5'd15};
        for (k = 0; k < 12; k++)
        begin
            if (k < 6)
                write_capacity(caps[k]);
            else
                write_capacity(CNT_W'($urandom_range(0, 31)));
            run_random_items(65, 75);
            run_random_items(65, 25);
        end
    endtask

    // long output hold while items keep coming, then a full drain
    task automatic test_output_backpressure();
        write_capacity(5'd16);
        wait_all_results();
        hold_req   = 1'b1;
        burst_left = 40;
        run_random_items(40, 70);
        wait_all_results();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        req_type    = REQ_PUSH;
        position    = '0;
        data_in     = '0;
        error_count = 0;
        offering    = 1'b0;
        burst_left  = 0;
        hold_req    = 1'b0;
        model_cap_reg = 5'(DEPTH);
        clear_queue_model();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_capacity_settings();
        test_output_backpressure();

        wait_all_results();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
